// ----- design/sba_pkg.sv -----
// Shared types and constants for the signed 64-bit ALU.
package sba_pkg;

	localparam int DataWidth = 64;
	localparam int HalfWidth = DataWidth / 2;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_REM = 3'd4
	} sba_op_t;

	typedef struct packed {
		logic [2:0]                  opcode;
		logic signed [DataWidth-1:0] operand_a;
		logic signed [DataWidth-1:0] operand_b;
	} sba_cmd_t;

	typedef struct packed {
		logic signed [DataWidth-1:0] result_value;
		logic                        divide_by_zero;
	} sba_rsp_t;

	// one divider stage: partial remainder, dividend shifting out / quotient shifting in
	typedef struct packed {
		logic                 valid;
		logic [2:0]           opcode;
		logic                 neg_q;
		logic                 neg_r;
		logic                 dz;
		logic [DataWidth-1:0] divisor;
		logic [DataWidth-1:0] rem;
		logic [DataWidth-1:0] dvd;
		logic [DataWidth-1:0] res;
	} sba_div_t;

endpackage

// ----- design/sba_front.sv -----
// Front end: add/sub, split multiply, operand magnitudes for the divider.
module sba_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  sba_pkg::sba_cmd_t cmd,
	output sba_pkg::sba_div_t d_out
);
	import sba_pkg::*;

	logic                 valid_s1, valid_s2;
	logic [2:0]           op_s1, op_s2;
	logic [DataWidth-1:0] addsub_s1;
	logic [DataWidth-1:0] p_ll_s1;
	logic [HalfWidth-1:0] p_lh_s1, p_hl_s1;
	logic [DataWidth-1:0] ma_s1, mb_s1, ma_s2, mb_s2;
	logic                 nq_s1, nr_s1, dz_s1, nq_s2, nr_s2, dz_s2;
	logic [DataWidth-1:0] res_s2;

	logic [DataWidth-1:0] a, b, mul_sum;
	logic [HalfWidth-1:0] mul_cross;
	logic                 is_div;

	assign a = cmd.operand_a;
	assign b = cmd.operand_b;
	assign is_div = (cmd.opcode == OP_DIV) || (cmd.opcode == OP_REM);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		op_s1     <= cmd.opcode;
		addsub_s1 <= (cmd.opcode == OP_SUB) ? a - b : a + b;
		p_ll_s1   <= a[HalfWidth-1:0] * b[HalfWidth-1:0];
		p_lh_s1   <= HalfWidth'(a[HalfWidth-1:0] * b[DataWidth-1:HalfWidth]);
		p_hl_s1   <= HalfWidth'(a[DataWidth-1:HalfWidth] * b[HalfWidth-1:0]);
		ma_s1     <= a[DataWidth-1] ? -a : a;
		mb_s1     <= b[DataWidth-1] ? -b : b;
		nq_s1     <= a[DataWidth-1] ^ b[DataWidth-1];
		nr_s1     <= a[DataWidth-1];
		dz_s1     <= is_div && (b == '0);
	end

	assign mul_cross = p_lh_s1 + p_hl_s1;
	assign mul_sum   = p_ll_s1 + {mul_cross, {HalfWidth{1'b0}}};

	always_ff @(posedge clk) begin
		op_s2 <= op_s1;
		ma_s2 <= ma_s1;
		mb_s2 <= mb_s1;
		nq_s2 <= nq_s1;
		nr_s2 <= nr_s1;
		dz_s2 <= dz_s1;
		unique case (op_s1)
			OP_ADD, OP_SUB: res_s2 <= addsub_s1;
			OP_MUL:         res_s2 <= mul_sum;
			default:        res_s2 <= '0;
		endcase
	end

	always_comb begin
		d_out.valid   = valid_s2;
		d_out.opcode  = op_s2;
		d_out.neg_q   = nq_s2;
		d_out.neg_r   = nr_s2;
		d_out.dz      = dz_s2;
		d_out.divisor = mb_s2;
		d_out.rem     = '0;
		d_out.dvd     = ma_s2;
		d_out.res     = res_s2;
	end
endmodule

// ----- design/sba_div_stage.sv -----
// One restoring-division step: one quotient bit per stage.
module sba_div_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  sba_pkg::sba_div_t d_in,
	output sba_pkg::sba_div_t d_out
);
	import sba_pkg::*;

	logic                 valid_s1;
	sba_div_t             pay_s1;
	sba_div_t             pay_next;
	logic [DataWidth:0]   trial, diff;
	logic                 take;

	assign trial = {d_in.rem, d_in.dvd[DataWidth-1]};
	assign diff  = trial - {1'b0, d_in.divisor};
	assign take  = !diff[DataWidth];

	always_comb begin
		pay_next     = d_in;
		pay_next.rem = take ? diff[DataWidth-1:0] : trial[DataWidth-1:0];
		pay_next.dvd = {d_in.dvd[DataWidth-2:0], take};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_s1 <= 1'b0;
		else         valid_s1 <= d_in.valid;
	end

	always_ff @(posedge clk) begin
		pay_s1 <= pay_next;
	end

	always_comb begin
		d_out       = pay_s1;
		d_out.valid = valid_s1;
	end
endmodule

// ----- design/sba_back.sv -----
// Back end: sign fix of quotient/remainder and result select.
module sba_back (
	input  logic              clk,
	input  logic              arst_n,
	input  sba_pkg::sba_div_t d_in,
	output logic              done,
	output sba_pkg::sba_rsp_t rsp
);
	import sba_pkg::*;

	logic     done_q;
	sba_rsp_t rsp_q;
	logic [DataWidth-1:0] q, r;

	assign q = d_in.neg_q ? -d_in.dvd : d_in.dvd;
	assign r = d_in.neg_r ? -d_in.rem : d_in.rem;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else         done_q <= d_in.valid;
	end

	always_ff @(posedge clk) begin
		rsp_q.divide_by_zero <= d_in.dz;
		if (d_in.dz) begin
			rsp_q.result_value <= '0;
		end else begin
			unique case (d_in.opcode)
				OP_DIV:  rsp_q.result_value <= q;
				OP_REM:  rsp_q.result_value <= r;
				default: rsp_q.result_value <= d_in.res;
			endcase
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;
endmodule

// ----- design/signed_64bit_alu.sv -----
// Registers from start to done, the same for every opcode: 2 front, 64 divider, 1 output.
// Throughput: one transaction per cycle; the 64-stage divider sets the latency.
// busy is held low: the pipeline never stalls and the receiver cannot stall it.
// Reset clears all valid bits at once; payload registers are not reset.
// Top level: signed 64-bit ALU, fully pipelined.
module signed_64bit_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  sba_pkg::sba_cmd_t cmd,
	output logic              done,
	output sba_pkg::sba_rsp_t rsp
);
	import sba_pkg::*;

	sba_div_t chain [DataWidth+1];

	assign busy = 1'b0;

	sba_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start),
		.cmd      (cmd),
		.d_out    (chain[0])
	);

	for (genvar i = 0; i < DataWidth; i++) begin : g_div
		sba_div_stage u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.d_in   (chain[i]),
			.d_out  (chain[i+1])
		);
	end

	sba_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.d_in   (chain[DataWidth]),
		.done   (done),
		.rsp    (rsp)
	);
endmodule
